FILE: sv/fixed_point_alu_assert.svh
// ----------------------------------------------------------------------------
// fixed_point_alu_assert.svh
// assertion macros used by the fixed-point alu top level
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// plain property, checked on every clock edge outside reset
`define FPA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("fixed_point_alu assertion failed");

// same-cycle implication
`define FPA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fixed_point_alu implication failed");

`endif

FILE: sv/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// types, constants and helpers of the signed fixed-point alu
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 4;
    localparam int NUM_W         = DATA_W + FRACTION_BITS;
    localparam int DIV_K         = 4;
    localparam int DIV_STAGES    = (NUM_W + DIV_K - 1) / DIV_K;
    localparam int NUM_PAD       = DIV_STAGES * DIV_K;
    localparam int REM_W         = DATA_W + 1;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int PIPE_DEPTH    = DIV_STAGES + 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_INC      = 4'd4,
        CMD_DEC      = 4'd5,
        CMD_MIN      = 4'd6,
        CMD_MAX      = 4'd7,
        CMD_COMPARE  = 4'd8,
        CMD_TO_INT   = 4'd9,
        CMD_FROM_INT = 4'd10
    } t_cmd;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic                     a_less;
        logic                     a_equal;
        logic                     a_greater;
        logic                     overflow_flag;
        logic                     divide_by_zero;
    } t_out;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DATA_W-1:0] simple_value;
        logic              simple_ovf;
        logic              divide_by_zero;
        logic              neg;
        logic              a_less;
        logic              a_equal;
        logic              a_greater;
        logic [PROD_W-1:0] product;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
    } t_front;

    typedef struct packed {
        logic [REM_W-1:0]   rem;
        logic [NUM_PAD-1:0] nq;
        logic [DATA_W-1:0]  divisor;
    } t_div;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              ovf;
    } t_sat;

    // saturate a sign-extended sum one bit wider than the data
    function automatic t_sat sat_narrow(input logic [DATA_W:0] x);
        t_sat s;
        s.ovf   = x[DATA_W] ^ x[DATA_W-1];
        s.value = s.ovf ? (x[DATA_W] ? Q_MIN : Q_MAX) : x[DATA_W-1:0];
        return s;
    endfunction

    // apply sign to a magnitude and saturate
    function automatic t_sat sat_mag(input logic [PROD_W:0] m, input logic neg);
        t_sat s;
        if (neg) begin
            s.ovf   = m > (PROD_W+1)'({1'b1, {(DATA_W-1){1'b0}}});
            s.value = s.ovf ? Q_MIN : (~m[DATA_W-1:0] + 1'b1);
        end else begin
            s.ovf   = m > (PROD_W+1)'(Q_MAX);
            s.value = s.ovf ? Q_MAX : m[DATA_W-1:0];
        end
        return s;
    endfunction

endpackage

FILE: sv/fpa_front.sv
// ----------------------------------------------------------------------------
// fpa_front
// first stage: compare, the simple commands with saturation, magnitudes
// ----------------------------------------------------------------------------
module fpa_front (
    input  logic           i_clk,
    input  logic           i_en,
    input  fpa_pkg::t_in    i_in,
    output fpa_pkg::t_front o_front
);
    import fpa_pkg::*;

    logic signed [DATA_W-1:0] w_a;
    logic signed [DATA_W-1:0] w_b;
    logic                     w_lt;
    logic                     w_eq;
    logic [DATA_W:0]          w_sum;
    logic [DATA_W:0]          w_dif;
    logic [DATA_W:0]          w_inc;
    logic [DATA_W:0]          w_dec;
    logic signed [NUM_W-1:0]  w_shl;
    logic                     w_shl_ovf;
    t_sat                     w_sat;
    t_front                   n_front;
    t_front                   r_front;

    assign w_a = i_in.operand_a;
    assign w_b = i_in.operand_b;
    assign w_lt = w_a < w_b;
    assign w_eq = w_a == w_b;
    assign w_sum = {w_a[DATA_W-1], w_a} + {w_b[DATA_W-1], w_b};
    assign w_dif = {w_a[DATA_W-1], w_a} - {w_b[DATA_W-1], w_b};
    assign w_inc = {w_a[DATA_W-1], w_a} + (DATA_W+1)'(1);
    assign w_dec = {w_a[DATA_W-1], w_a} - (DATA_W+1)'(1);
    assign w_shl = NUM_W'(w_a) <<< FRACTION_BITS;
    assign w_shl_ovf = (w_shl[NUM_W-1:DATA_W-1] != '0) && (w_shl[NUM_W-1:DATA_W-1] != '1);

    always_comb begin
        w_sat = '0;
        case (i_in.command)
            CMD_ADD: begin
                w_sat = sat_narrow(w_sum);
            end
            CMD_SUB: begin
                w_sat = sat_narrow(w_dif);
            end
            CMD_INC: begin
                w_sat = sat_narrow(w_inc);
            end
            CMD_DEC: begin
                w_sat = sat_narrow(w_dec);
            end
            CMD_MIN: begin
                w_sat.value = w_lt ? w_a : w_b;
            end
            CMD_MAX: begin
                w_sat.value = (!w_lt && !w_eq) ? w_a : w_b;
            end
            CMD_TO_INT: begin
                w_sat.value = w_a >>> FRACTION_BITS;
            end
            CMD_FROM_INT: begin
                w_sat.ovf   = w_shl_ovf;
                w_sat.value = w_shl_ovf ? (w_a[DATA_W-1] ? Q_MIN : Q_MAX)
                                        : w_shl[DATA_W-1:0];
            end
            default: begin
                w_sat = '0;
            end
        endcase
    end

    always_comb begin
        n_front.side.command        = i_in.command;
        n_front.side.simple_value   = w_sat.value;
        n_front.side.simple_ovf     = w_sat.ovf;
        n_front.side.divide_by_zero = (i_in.command == CMD_DIV) && (w_b == '0);
        n_front.side.neg            = w_a[DATA_W-1] ^ w_b[DATA_W-1];
        n_front.side.a_less         = w_lt;
        n_front.side.a_equal        = w_eq;
        n_front.side.a_greater      = !w_lt && !w_eq;
        n_front.side.product        = '0;
        n_front.mag_a = w_a[DATA_W-1] ? (~w_a + 1'b1) : w_a;
        n_front.mag_b = w_b[DATA_W-1] ? (~w_b + 1'b1) : w_b;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_front <= n_front;
        end
    end

    assign o_front = r_front;

endmodule

FILE: sv/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage
// one register stage of the restoring divider, several quotient bits each
// ----------------------------------------------------------------------------
module fpa_div_stage (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_div  i_div,
    input  fpa_pkg::t_side i_side,
    output fpa_pkg::t_div  o_div,
    output fpa_pkg::t_side o_side
);
    import fpa_pkg::*;

    logic [REM_W-1:0] w_trial;
    t_div             n_div;
    t_div             r_div;
    t_side            r_side;

    always_comb begin
        n_div   = i_div;
        w_trial = '0;
        for (int k = 0; k < DIV_K; k++) begin
            w_trial  = {n_div.rem[REM_W-2:0], n_div.nq[NUM_PAD-1]};
            n_div.nq = {n_div.nq[NUM_PAD-2:0], 1'b0};
            if (w_trial >= {1'b0, n_div.divisor}) begin
                n_div.rem   = w_trial - {1'b0, n_div.divisor};
                n_div.nq[0] = 1'b1;
            end else begin
                n_div.rem = w_trial;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div  <= n_div;
            r_side <= i_side;
        end
    end

    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

FILE: sv/fpa_back.sv
// ----------------------------------------------------------------------------
// fpa_back
// last stage: product and quotient rounding, saturation, result select
// ----------------------------------------------------------------------------
module fpa_back (
    input  logic          i_clk,
    input  logic          i_en,
    input  fpa_pkg::t_div  i_div,
    input  fpa_pkg::t_side i_side,
    output fpa_pkg::t_out  o_out
);
    import fpa_pkg::*;

    logic [PROD_W:0] w_mul_mag;
    logic [PROD_W:0] w_div_mag;
    logic            w_round_up;
    t_sat            w_mul_sat;
    t_sat            w_div_sat;
    t_out            n_out;
    t_out            r_out;

    assign w_mul_mag  = ({1'b0, i_side.product} + (PROD_W+1)'(1 << (FRACTION_BITS - 1)))
                        >> FRACTION_BITS;
    assign w_round_up = {i_div.rem, 1'b0} >= {2'b00, i_div.divisor};
    assign w_div_mag  = (PROD_W+1)'(i_div.nq) + (PROD_W+1)'(w_round_up);
    assign w_mul_sat  = sat_mag(w_mul_mag, i_side.neg);
    assign w_div_sat  = sat_mag(w_div_mag, i_side.neg);

    always_comb begin
        n_out.a_less         = i_side.a_less;
        n_out.a_equal        = i_side.a_equal;
        n_out.a_greater      = i_side.a_greater;
        n_out.divide_by_zero = i_side.divide_by_zero;
        case (i_side.command)
            CMD_MUL: begin
                n_out.result_value  = w_mul_sat.value;
                n_out.overflow_flag = w_mul_sat.ovf;
            end
            CMD_DIV: begin
                n_out.result_value  = i_side.divide_by_zero ? '0 : w_div_sat.value;
                n_out.overflow_flag = !i_side.divide_by_zero && w_div_sat.ovf;
            end
            default: begin
                n_out.result_value  = i_side.simple_value;
                n_out.overflow_flag = i_side.simple_ovf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

FILE: sv/fixed_point_alu.sv
// ----------------------------------------------------------------------------
// fixed_point_alu
// signed q24.8 alu: add, sub, mul, div, inc, dec, min, max, compare, converts
//
//   channel  | valid   | stall   | payload
//   ---------+---------+---------+--------------------
//   input    | i_valid | o_stall | i_data (t_in)
//   result   | o_valid | i_stall | o_data (t_out)
//
// one transfer per cycle in each direction unless a stall holds it
// depth set by the divider stages, four quotient bits per stage
// each stage holds only while it is full and the next one holds
// reset clears the valid bits only
// ----------------------------------------------------------------------------
module fixed_point_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fpa_pkg::t_in   i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output fpa_pkg::t_out  o_data
);
    import fpa_pkg::*;
    `include "fixed_point_alu_assert.svh"

    logic [PIPE_DEPTH-1:0] r_valid;
    logic [PIPE_DEPTH-1:0] n_valid;
    logic [PIPE_DEPTH-1:0] w_en;
    t_front                w_front;
    t_side                 n_s1_side;
    t_div                  n_s1_div;
    t_side                 r_s1_side;
    t_div                  r_s1_div;
    t_div                  w_div  [DIV_STAGES+1];
    t_side                 w_side [DIV_STAGES+1];

    // stage holds only while full and blocked downstream
    always_comb begin
        w_en[PIPE_DEPTH-1] = !r_valid[PIPE_DEPTH-1] || !i_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign n_valid = {r_valid[PIPE_DEPTH-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= n_valid[k];
                end
            end
        end
    end

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_en    (w_en[0]),
        .i_in    (i_data),
        .o_front (w_front)
    );

    // multiply and divider setup
    always_comb begin
        n_s1_side         = w_front.side;
        n_s1_side.product = PROD_W'(w_front.mag_a) * PROD_W'(w_front.mag_b);
        n_s1_div.rem      = '0;
        n_s1_div.nq       = NUM_PAD'(w_front.mag_a) << FRACTION_BITS;
        n_s1_div.divisor  = w_front.mag_b;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_side <= n_s1_side;
            r_s1_div  <= n_s1_div;
        end
    end

    assign w_div[0]  = r_s1_div;
    assign w_side[0] = r_s1_side;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        fpa_div_stage u_div (
            .i_clk  (i_clk),
            .i_en   (w_en[g+2]),
            .i_div  (w_div[g]),
            .i_side (w_side[g]),
            .o_div  (w_div[g+1]),
            .o_side (w_side[g+1])
        );
    end

    fpa_back u_back (
        .i_clk  (i_clk),
        .i_en   (w_en[PIPE_DEPTH-1]),
        .i_div  (w_div[DIV_STAGES]),
        .i_side (w_side[DIV_STAGES]),
        .o_out  (o_data)
    );

    assign o_stall = !w_en[0];
    assign o_valid = r_valid[PIPE_DEPTH-1];

    `FPA_ASSERT_IMPL(a_stall_cause, o_stall, r_valid[PIPE_DEPTH-1] && i_stall)
    `FPA_ASSERT_IMPL(a_cmp_onehot, o_valid, $onehot({o_data.a_less, o_data.a_equal, o_data.a_greater}))
    `FPA_ASSERT_IMPL(a_dbz_zero, o_valid && o_data.divide_by_zero, (o_data.result_value == '0) && !o_data.overflow_flag)

endmodule
